// File: rtl/ntsc_pixel_composite_encoder_top_macros.svh
// ---------------------------------------------------------------------------
// ntsc pixel composite encoder assertion macros
// shared property templates for the encoder checker
// ---------------------------------------------------------------------------
`ifndef NTSC_PIXEL_COMPOSITE_ENCODER_TOP_MACROS_SVH
`define NTSC_PIXEL_COMPOSITE_ENCODER_TOP_MACROS_SVH

// same-cycle implication, ignored while reset is held
`define NPCE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("npce assertion failed");

// next-cycle implication, ignored while reset is held
`define NPCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("npce assertion failed");

`endif

// File: rtl/npce_pkg.sv
// ---------------------------------------------------------------------------
// npce_pkg
// widths, level tables and the per-sample waveform function of the encoder
// ---------------------------------------------------------------------------
package npce_pkg;

    localparam int CODE_W   = 9;
    localparam int PHASE_W  = 4;
    localparam int OFFSET_W = 10;
    localparam int LEVEL_W  = 8;
    localparam int SUM_W    = 12;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 8;

    localparam logic [PHASE_W-1:0] PHASE_MOD  = 4'd12;
    localparam logic [PHASE_W-1:0] PHASE_STEP = 4'd3;

    localparam logic [3:0] HUE_ALWAYS_LOW = 4'd13;
    localparam logic [3:0] HUE_BLANK_MIN  = 4'd14;

    typedef logic signed [LEVEL_W-1:0] t_level;
    typedef logic [CODE_W-1:0]         t_code;
    typedef logic [PHASE_W-1:0]        t_phase;

    // [attenuated][luma row]
    localparam t_level LVL_HIGH [0:1][0:3] = '{
        '{8'sd43, 8'sd74, 8'sd110, 8'sd110},
        '{8'sd26, 8'sd51, 8'sd82,  8'sd82 }
    };
    localparam t_level LVL_LOW [0:1][0:3] = '{
        '{-8'sd12, 8'sd0,  8'sd34, 8'sd80},
        '{-8'sd17, -8'sd8, 8'sd19, 8'sd56}
    };

    // emphasis bits 8:6 that dim each half-phase slot
    localparam logic [2:0] EMPH_MASK [0:5] = '{
        3'b011, 3'b001, 3'b101, 3'b100, 3'b110, 3'b010
    };

    // one square-wave sample of a pixel code at phase q (q below 19)
    function automatic t_level sample_at(input t_code code, input logic [4:0] q);
        logic [3:0] hue;
        logic [1:0] row;
        logic [5:0] hq;
        logic [5:0] hm;
        logic [3:0] slot;
        logic       att;
        logic       hi;
        t_level     lv;
        hue = code[3:0];
        row = code[5:4];
        hq  = {2'b00, hue} + {1'b0, q};
        if (hq >= 6'd24) begin
            hm = hq - 6'd24;
        end else if (hq >= 6'd12) begin
            hm = hq - 6'd12;
        end else begin
            hm = hq;
        end
        hi   = (hm < 6'd6);
        slot = q[4:1];
        if (slot >= 4'd6) begin
            slot = slot - 4'd6;
        end
        att = |(code[8:6] & EMPH_MASK[slot[2:0]]);
        priority if (hue == 4'd0) begin
            lv = LVL_HIGH[att][row];
        end else if (hue == HUE_ALWAYS_LOW) begin
            lv = LVL_LOW[att][row];
        end else if (hue >= HUE_BLANK_MIN) begin
            lv = '0;
        end else if (hi) begin
            lv = LVL_HIGH[att][row];
        end else begin
            lv = LVL_LOW[att][row];
        end
        return lv;
    endfunction

endpackage

// File: rtl/ntsc_pixel_composite_encoder_top.sv
// ---------------------------------------------------------------------------
// ntsc_pixel_composite_encoder_top
// composite video level encoder for 9-bit pixel codes, unless stalled one pixel per clock
// ---------------------------------------------------------------------------
//  channel   | direction | handshake                 | content
//  ----------+-----------+---------------------------+----------------------------
//  s_axis    | in        | i_s_axis_tvalid/o_..ready | pixel code, phase, line start
//  m_axis    | out       | o_m_axis_tvalid/i_..ready | 8-bit signed composite level
//  cfg       | in        | i_cfg_valid/o_cfg_ready   | black offset, 10-bit signed
//
//  two register stages: a pixel request lands in the input stage, then its
//  four samples are summed into the output register when it is free or drains
//  one pixel per clock unless m_axis stalls; the phase update is a single add-and-wrap
//  i_rst_n is synchronous, active low; clears valids, phase and black offset
//  a stalled output holds its level; the input stage keeps filling until
//  both stages are full, then s_axis ready drops
// ---------------------------------------------------------------------------
module ntsc_pixel_composite_encoder_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // pixel requests
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [8:0] pixel_code, [12:9] start_phase, [15:13] zero
    input  logic [npce_pkg::S_DATA_W-1:0]   i_s_axis_tdata,
    // [0] start_of_line
    input  logic                            i_s_axis_tuser,
    // composite levels
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [7:0] composite_level
    output logic [npce_pkg::M_DATA_W-1:0]   o_m_axis_tdata,
    // black offset writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [npce_pkg::OFFSET_W-1:0]   i_cfg_data
);
    import npce_pkg::*;

    // configuration
    logic signed [OFFSET_W-1:0] r_black_offset;

    // running colour phase, always below twelve after the first pixel
    t_phase r_phase;
    t_phase ph_in;
    t_phase n_phase;
    logic [PHASE_W:0] ph_plus;

    // input stage
    logic   r_s1_valid;
    t_code  r_s1_code;
    t_phase r_s1_phase;

    // output stage
    logic   r_out_valid;
    t_level r_out_level;

    logic in_acc;
    logic s1_adv;

    logic signed [SUM_W-1:0] sum;
    t_level                  smp [0:3];

    assign o_cfg_ready = 1'b1;

    // input stage may move on whenever the output register is free or drains
    assign s1_adv          = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_valid || s1_adv;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    // a line start loads its phase before the pixel is encoded
    assign ph_in   = i_s_axis_tuser ? i_s_axis_tdata[CODE_W +: PHASE_W] : r_phase;
    assign ph_plus = {1'b0, ph_in} + {1'b0, PHASE_STEP};
    assign n_phase = (ph_plus >= {1'b0, PHASE_MOD}) ?
                     PHASE_W'(ph_plus - {1'b0, PHASE_MOD}) : ph_plus[PHASE_W-1:0];

    // four samples at ph .. ph+3, summed with the black offset
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            smp[k] = sample_at(r_s1_code, 5'({1'b0, r_s1_phase}) + 5'(k));
        end
        sum = SUM_W'(r_black_offset)
            + SUM_W'(smp[0]) + SUM_W'(smp[1])
            + SUM_W'(smp[2]) + SUM_W'(smp[3]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_black_offset <= '0;
            r_phase        <= '0;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_black_offset <= i_cfg_data;
            end
            if (in_acc) begin
                r_phase <= n_phase;
            end
            if (o_s_axis_tready) begin
                r_s1_valid <= in_acc;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_code  <= i_s_axis_tdata[CODE_W-1:0];
            r_s1_phase <= ph_in;
        end
        if (s1_adv && r_s1_valid) begin
            // floor divide by four, low byte kept (wraps)
            r_out_level <= sum[LEVEL_W+1:2];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_level;

endmodule

// File: rtl/npce_checker.sv
// ---------------------------------------------------------------------------
// npce_checker
// port-level checks of the composite encoder, bound to the top level
// ---------------------------------------------------------------------------
`include "ntsc_pixel_composite_encoder_top_macros.svh"

module npce_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic [npce_pkg::S_DATA_W-1:0]   i_s_axis_tdata,
    input logic                            i_s_axis_tuser,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [npce_pkg::M_DATA_W-1:0]   o_m_axis_tdata,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic [npce_pkg::OFFSET_W-1:0]   i_cfg_data
);
    import npce_pkg::*;

    // stalled result keeps both valid and level
    `NPCE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // empty output register never back-pressures the input
    `NPCE_ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n, !o_m_axis_tvalid, o_s_axis_tready)

    // an accepted pixel reaches the output if the sink is ready while it sits in the input stage
    `NPCE_ASSERT_NEXT(a_latency, i_clk, i_rst_n, (i_s_axis_tvalid && o_s_axis_tready) ##1 i_m_axis_tready, o_m_axis_tvalid)

endmodule

bind ntsc_pixel_composite_encoder_top npce_checker u_npce_checker (.*);
